// ----- hw/rtl/pdcs_pkg.sv -----
`default_nettype none

package pdcs_pkg;

  // field and counter widths
  localparam int COUNT_WIDTH = 32;
  localparam int VALUE_WIDTH = 16;
  localparam int RES_WIDTH   = 16;

  // configuration register indexes
  localparam int CFG_IDX_WIDTH = 1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_SENSOR_RESOLUTION = 1'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_ACTIVE_HIGH       = 1'd1;

  localparam logic [RES_WIDTH-1:0] RESOLUTION_RESET = 16'd4096;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = '1;

  // divider sizing: dividend is on_ticks * (resolution + 1)
  localparam int MULT_WIDTH = RES_WIDTH + 1;
  localparam int PROD_WIDTH = COUNT_WIDTH + MULT_WIDTH;
  localparam int QR_WIDTH   = PROD_WIDTH + 1;
  localparam int STEP_WIDTH = $clog2(PROD_WIDTH);

  // queue between capture front end and divider back end
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_WIDTH  = QPTR_WIDTH + 1;

  // one finished period waiting for scaling
  typedef struct packed {
    logic [RES_WIDTH-1:0]   resolution;
    logic [COUNT_WIDTH-1:0] on_ticks;
    logic [COUNT_WIDTH-1:0] period_ticks;
    logic                   overflow;
  } pdcs_entry_t;

  typedef struct packed {
    logic        valid;
    pdcs_entry_t entry;
  } pdcs_slot_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pdcs_if.sv -----
`default_nettype none

// pin sample channel
interface pdcs_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink (input valid, input pin_level, output ready);
endinterface

// capture result channel
interface pdcs_out_if;
  import pdcs_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] scaled_value;
  logic [COUNT_WIDTH-1:0] on_ticks;
  logic [COUNT_WIDTH-1:0] period_ticks;
  logic                   period_overflow;

  modport source (output valid, output scaled_value, output on_ticks,
                  output period_ticks, output period_overflow, input ready);
  modport sink (input valid, input scaled_value, input on_ticks,
                input period_ticks, input period_overflow, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/pdcs_front.sv -----
`default_nettype none

module pdcs_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [pdcs_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  wire logic [pdcs_pkg::RES_WIDTH-1:0]   cfg_data,
  pdcs_in_if.sink                               samples,
  input  wire logic                             full,
  output pdcs_pkg::pdcs_slot_t                  push
);
  import pdcs_pkg::*;

  logic [RES_WIDTH-1:0]   resolution;
  logic                   active_high;
  logic [COUNT_WIDTH-1:0] period_count;
  logic [COUNT_WIDTH-1:0] on_count;
  logic                   previous_active;
  logic                   first_edge_seen;
  logic                   saturated_flag;

  logic accept;
  logic active;
  logic edge_hit;

  // sample transfer and edge detect
  assign samples.ready = !full;
  assign accept   = samples.valid && samples.ready;
  assign active   = (samples.pin_level == active_high);
  assign edge_hit = active && !previous_active;

  // finished period goes to the queue
  always_comb begin
    push.valid               = accept && edge_hit && first_edge_seen;
    push.entry.resolution    = resolution;
    push.entry.on_ticks      = on_count;
    push.entry.period_ticks  = period_count;
    push.entry.overflow      = saturated_flag;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      resolution  <= RESOLUTION_RESET;
      active_high <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SENSOR_RESOLUTION: resolution  <= cfg_data;
        CFG_ACTIVE_HIGH:       active_high <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // saturating period and on-time counters
  always_ff @(posedge clk) begin
    if (rst) begin
      period_count    <= '0;
      on_count        <= '0;
      previous_active <= 1'b0;
      first_edge_seen <= 1'b0;
      saturated_flag  <= 1'b0;
    end else if (accept) begin
      previous_active <= active;
      if (edge_hit) begin
        first_edge_seen <= 1'b1;
        period_count    <= COUNT_WIDTH'(1);
        on_count        <= COUNT_WIDTH'(1);
        saturated_flag  <= 1'b0;
      end else if (period_count != COUNT_MAX) begin
        period_count <= period_count + COUNT_WIDTH'(1);
        if (active && on_count != COUNT_MAX) begin
          on_count <= on_count + COUNT_WIDTH'(1);
        end
      end else begin
        saturated_flag <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/pdcs_queue.sv -----
`default_nettype none

module pdcs_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  pdcs_pkg::pdcs_slot_t push,
  input  wire logic           pop,
  output pdcs_pkg::pdcs_slot_t head,
  output logic                full
);
  import pdcs_pkg::*;

  pdcs_entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0]  wptr;
  logic [QPTR_WIDTH-1:0]  rptr;
  logic [QCNT_WIDTH-1:0]  count;

  assign full       = (count == QCNT_WIDTH'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.entry = slots[rptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wptr] <= push.entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push.valid) begin
        wptr <= wptr + QPTR_WIDTH'(1);
      end
      if (pop) begin
        rptr <= rptr + QPTR_WIDTH'(1);
      end
      case ({push.valid, pop})
        2'b10:   count <= count + QCNT_WIDTH'(1);
        2'b01:   count <= count - QCNT_WIDTH'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_WIDTH'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from empty queue");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push.valid && !pop) |=> count == $past(count) + QCNT_WIDTH'(1))
    else $error("queue count did not follow push");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/pdcs_back.sv -----
`default_nettype none

module pdcs_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  pdcs_pkg::pdcs_slot_t head,
  output logic                 pop,
  pdcs_out_if.source           results
);
  import pdcs_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_ROUND} state_t;

  state_t                 state;
  pdcs_entry_t            cur;
  logic [PROD_WIDTH-1:0]  quo;
  logic [COUNT_WIDTH-1:0] rem;
  logic [STEP_WIDTH-1:0]  step;

  logic                   res_valid;
  logic [VALUE_WIDTH-1:0] res_value;
  logic [COUNT_WIDTH-1:0] res_on;
  logic [COUNT_WIDTH-1:0] res_period;
  logic                   res_overflow;

  logic [MULT_WIDTH-1:0]  mult;
  logic [PROD_WIDTH-1:0]  product;
  logic [COUNT_WIDTH:0]   trial;
  logic [COUNT_WIDTH:0]   trial_diff;
  logic                   trial_ge;
  logic [COUNT_WIDTH:0]   half_sum;
  logic                   round_up;
  logic [QR_WIDTH-1:0]    q_round;
  logic [QR_WIDTH-1:0]    q_minus;
  logic [VALUE_WIDTH-1:0] value_next;
  logic                   out_free;

  assign pop      = (state == S_IDLE) && head.valid;
  assign out_free = !res_valid || results.ready;

  // multiply, restoring divide step and rounding
  always_comb begin
    mult       = {1'b0, cur.resolution} + MULT_WIDTH'(1);
    product    = PROD_WIDTH'(cur.on_ticks) * PROD_WIDTH'(mult);
    trial      = {rem, quo[PROD_WIDTH-1]};
    trial_ge   = (trial >= {1'b0, cur.period_ticks});
    trial_diff = trial - {1'b0, cur.period_ticks};
    half_sum   = {1'b0, rem} + {2'b00, cur.period_ticks[COUNT_WIDTH-1:1]};
    round_up   = (half_sum >= {1'b0, cur.period_ticks});
    q_round    = {1'b0, quo} + QR_WIDTH'(round_up);
    if (cur.period_ticks == '0) begin
      q_round = '0;
    end
    q_minus = q_round - QR_WIDTH'(1);
    if (q_round == '0) begin
      value_next = '0;
    end else if (q_minus > QR_WIDTH'(VALUE_MAX)) begin
      value_next = VALUE_MAX;
    end else begin
      value_next = q_minus[VALUE_WIDTH-1:0];
    end
  end

  // sequencer with output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      // output register fill and transfer
      if (state == S_ROUND && out_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && results.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (head.valid) begin
            cur   <= head.entry;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          quo   <= product;
          rem   <= '0;
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          quo  <= {quo[PROD_WIDTH-2:0], trial_ge};
          rem  <= trial_ge ? trial_diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
          step <= step + STEP_WIDTH'(1);
          if (step == STEP_WIDTH'(PROD_WIDTH - 1)) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          if (out_free) begin
            res_value    <= value_next;
            res_on       <= cur.on_ticks;
            res_period   <= cur.period_ticks;
            res_overflow <= cur.overflow;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign results.valid           = res_valid;
  assign results.scaled_value    = res_value;
  assign results.on_ticks        = res_on;
  assign results.period_ticks    = res_period;
  assign results.period_overflow = res_overflow;

endmodule

`default_nettype wire

// ----- hw/rtl/pwm_duty_capture_scaler.sv -----
// PWM duty capture and scaling. One pin sample is taken per transfer; a pin is
// active when its level equals active_high. Each active-going edge after the
// first closes a period and yields one result: on-time, period length, an
// overflow flag set when the period counter saturated, and
// round(on*(resolution+1)/period)-1 clamped to 0..65535. The capture front end
// accepts one sample per clock as long as its four-entry period queue has room;
// samples.ready drops while the queue is full. The back end scales one period
// at a time (queue pop, one 32x17 multiply, 49 restoring-divide steps, one
// rounding step), so short periods drain slower than they arrive and, once the
// queue fills, the sample input stalls. Results sit in an output register and
// the back end moves on as soon as that register is taken.
`default_nettype none

module pwm_duty_capture_scaler (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [pdcs_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  wire logic [pdcs_pkg::RES_WIDTH-1:0]     cfg_data,
  pdcs_in_if.sink                                 samples,
  pdcs_out_if.source                              results
);
  import pdcs_pkg::*;

  pdcs_slot_t push;
  pdcs_slot_t head;
  logic       full;
  logic       pop;

  // edge detect and period counting
  pdcs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples),
    .full      (full),
    .push      (push)
  );

  // finished periods waiting for scaling
  pdcs_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (full)
  );

  // scaling divider and output register
  pdcs_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .pop     (pop),
    .results (results)
  );

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pdcs_pkg::*;

  // one finished period as seen on the result channel
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] scaled_value;
    logic [COUNT_WIDTH-1:0] on_ticks;
    logic [COUNT_WIDTH-1:0] period_ticks;
    logic                   period_overflow;
  } duty_result_t;

  typedef enum logic [1:0] {ROW_PIN, ROW_RES, ROW_POL} row_kind_t;

  // directed row: a pin sample or a register write, with an optional fixed result
  typedef struct packed {
    row_kind_t    kind;
    logic [15:0]  data;
    logic         pinned;
    duty_result_t want;
  } plan_row_t;

  localparam duty_result_t NO_RESULT = '0;
  localparam int DIR_ROWS   = 31;
  localparam int SETTLE_CYC = 300;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES     = 6;
  localparam int PHASE_ITEMS = 233;

  // directed stimulus, starting from reset values (resolution 4096, active high)
  plan_row_t plan [DIR_ROWS] = '{
    // active on the very first tick: first edge, no result
    '{ROW_PIN, 16'd1, 1'b0, NO_RESULT},
    '{ROW_PIN, 16'd1, 1'b0, NO_RESULT},
    '{ROW_PIN, 16'd0, 1'b0, NO_RESULT},
    '{ROW_PIN, 16'd0, 1'b0, NO_RESULT},
    '{ROW_PIN, 16'd1, 1'b1, '{16'd2048, 32'd2, 32'd4, 1'b0}},
    '{ROW_PIN, 16'd1, 1'b0, NO_RESULT},
    '{ROW_PIN, 16'd1, 1'b0, NO_RESULT},
    '{ROW_PIN, 16'd0, 1'b0, NO_RESULT},
    // widest on-time for the period
    '{ROW_PIN, 16'd1, 1'b1, '{16'd3072, 32'd3, 32'd4, 1'b0}},
    '{ROW_PIN, 16'd0, 1'b0, NO_RESULT},
    // shortest period
    '{ROW_PIN, 16'd1, 1'b1, '{16'd2048, 32'd1, 32'd2, 1'b0}},
    // full-scale resolution, multiplier 65536
    '{ROW_RES, 16'hFFFF, 1'b0, NO_RESULT},
    '{ROW_PIN, 16'd0, 1'b0, NO_RESULT},
    '{ROW_PIN, 16'd0, 1'b0, NO_RESULT},
    '{ROW_PIN, 16'd1, 1'b1, '{16'd21844, 32'd1, 32'd3, 1'b0}},
    '{ROW_PIN, 16'd1, 1'b0, NO_RESULT},
    '{ROW_PIN, 16'd0, 1'b0, NO_RESULT},
    // zero resolution, multiplier one
    '{ROW_RES, 16'h0000, 1'b0, NO_RESULT},
    '{ROW_PIN, 16'd0, 1'b0, NO_RESULT},
    '{ROW_PIN, 16'd1, 1'b1, '{16'd0, 32'd2, 32'd4, 1'b0}},
    '{ROW_PIN, 16'd0, 1'b0, NO_RESULT},
    '{ROW_PIN, 16'd0, 1'b0, NO_RESULT},
    // rounded quotient of zero clamps to zero
    '{ROW_PIN, 16'd1, 1'b1, '{16'd0, 32'd1, 32'd3, 1'b0}},
    '{ROW_PIN, 16'd0, 1'b0, NO_RESULT},
    // polarity flip turns the idle low level into an active-going edge
    '{ROW_POL, 16'hFFFE, 1'b0, NO_RESULT},
    '{ROW_PIN, 16'd0, 1'b1, '{16'd0, 32'd1, 32'd2, 1'b0}},
    // resolution one, multiplier two
    '{ROW_RES, 16'h0001, 1'b0, NO_RESULT},
    '{ROW_PIN, 16'd1, 1'b0, NO_RESULT},
    '{ROW_PIN, 16'd1, 1'b0, NO_RESULT},
    '{ROW_PIN, 16'd0, 1'b0, NO_RESULT},
    '{ROW_POL, 16'h0001, 1'b0, NO_RESULT}
  };

  logic clk;
  logic rst;
  logic                     cfg_we;
  logic [CFG_IDX_WIDTH-1:0] cfg_index;
  logic [RES_WIDTH-1:0]     cfg_data;

  pdcs_in_if  samples_if ();
  pdcs_out_if results_if ();

  pwm_duty_capture_scaler dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .samples   (samples_if),
    .results   (results_if)
  );

  // capture tracker state and register shadow
  logic [COUNT_WIDTH-1:0] trk_period;
  logic [COUNT_WIDTH-1:0] trk_on;
  bit                     trk_prev_active;
  bit                     trk_edge_seen;
  bit                     trk_saturated;
  logic [RES_WIDTH-1:0]   shadow_res;
  bit                     shadow_active_high;

  duty_result_t pending_results [$];
  int           err_count;
  int           idle_cycles;

  // fixed result for the directed sample now being offered
  logic         pinned_valid;
  duty_result_t pinned_want;

  int burst_left;
  bit gaps_on;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic note_error(input string msg);
    $display("tb: %s", msg);
    err_count++;
  endtask

  // advance the capture tracker by one accepted pin sample
  task automatic track_pin(input logic lvl, output bit emitted, output duty_result_t res);
    bit          active;
    logic [63:0] prod;
    logic [63:0] quo;
    logic [63:0] val;
    active  = (lvl == shadow_active_high);
    emitted = 1'b0;
    res     = NO_RESULT;
    if (active && !trk_prev_active) begin
      if (trk_edge_seen) begin
        prod = 64'(trk_on) * (64'(shadow_res) + 64'd1);
        if (trk_period == '0)
          quo = '0;
        else
          quo = (prod + 64'(trk_period >> 1)) / 64'(trk_period);
        val = (quo == 64'd0) ? 64'd0 : quo - 64'd1;
        if (val > 64'(VALUE_MAX))
          val = 64'(VALUE_MAX);
        res.scaled_value    = val[VALUE_WIDTH-1:0];
        res.on_ticks        = trk_on;
        res.period_ticks    = trk_period;
        res.period_overflow = trk_saturated;
        emitted = 1'b1;
      end
      trk_edge_seen = 1'b1;
      trk_period    = COUNT_WIDTH'(1);
      trk_on        = COUNT_WIDTH'(1);
      trk_saturated = 1'b0;
    end else if (trk_period != COUNT_MAX) begin
      trk_period++;
      if (active && trk_on != COUNT_MAX)
        trk_on++;
    end else begin
      trk_saturated = 1'b1;
    end
    trk_prev_active = active;
  endtask

  // track register writes and samples, check results against pending ones
  always @(posedge clk) begin
    bit           emitted;
    duty_result_t res;
    duty_result_t want;
    if (rst) begin
      trk_period         <= '0;
      trk_on             <= '0;
      trk_prev_active    <= 1'b0;
      trk_edge_seen      <= 1'b0;
      trk_saturated      <= 1'b0;
      shadow_res         <= RESOLUTION_RESET;
      shadow_active_high <= 1'b1;
    end else begin
      if (results_if.valid && results_if.ready) begin
        if (pending_results.size() == 0) begin
          note_error($sformatf("result with none pending: value %0d on %0d period %0d",
                               results_if.scaled_value, results_if.on_ticks,
                               results_if.period_ticks));
        end else begin
          want = pending_results.pop_front();
          if (results_if.scaled_value !== want.scaled_value)
            note_error($sformatf("scaled_value got %0d want %0d",
                                 results_if.scaled_value, want.scaled_value));
          if (results_if.on_ticks !== want.on_ticks)
            note_error($sformatf("on_ticks got %0d want %0d",
                                 results_if.on_ticks, want.on_ticks));
          if (results_if.period_ticks !== want.period_ticks)
            note_error($sformatf("period_ticks got %0d want %0d",
                                 results_if.period_ticks, want.period_ticks));
          if (results_if.period_overflow !== want.period_overflow)
            note_error($sformatf("period_overflow got %0d want %0d",
                                 results_if.period_overflow, want.period_overflow));
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_SENSOR_RESOLUTION)
          shadow_res = cfg_data;
        else if (cfg_index == CFG_ACTIVE_HIGH)
          shadow_active_high = cfg_data[0];
      end
      if (samples_if.valid && samples_if.ready) begin
        track_pin(samples_if.pin_level, emitted, res);
        if (pinned_valid)
          pending_results.push_back(pinned_want);
        else if (emitted)
          pending_results.push_back(res);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (samples_if.valid && samples_if.ready) ||
        (results_if.valid && results_if.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // receiver: changes stall mode now and then, including stretches of no stall
  initial begin
    int         mode;
    int         mode_left;
    int         tick;
    logic [7:0] pat;
    bit         rdy;
    mode      = 0;
    mode_left = 0;
    tick      = 0;
    pat       = 8'hFF;
    results_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 300);
        pat       = 8'($urandom) | 8'h01;
      end
      mode_left--;
      tick++;
      case (mode)
        0: rdy = 1'b1;
        1: rdy = pat[tick[2:0]];
        2: rdy = 1'($urandom_range(0, 1));
        default: rdy = (tick % 16) == 0;
      endcase
      results_if.ready <= rdy;
    end
  end

  // offer one pin sample and wait for its transfer; may open a gap between bursts
  task automatic put_sample(input logic lvl, input logic pinned, input duty_result_t want);
    int gap;
    if (burst_left == 0) begin
      gap = 0;
      if (gaps_on && $urandom_range(0, 3) != 0)
        gap = $urandom_range(1, 8);
      if (gap > 0) begin
        samples_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    samples_if.valid     <= 1'b1;
    samples_if.pin_level <= lvl;
    pinned_valid         <= pinned;
    pinned_want          <= want;
    @(posedge clk);
    while (!samples_if.ready) @(posedge clk);
  endtask

  // stop sending, wait for every pending result, then let the back end go quiet
  task automatic settle();
    samples_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [RES_WIDTH-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // main stimulus
  initial begin
    int              phase;
    int              sent;
    int              choice;
    int              n;
    int              per;
    int              on_len;
    bit              paused;
    logic            ah;
    logic [RES_WIDTH-1:0] res;
    err_count    = 0;
    burst_left   = 0;
    gaps_on      = 1'b1;
    paused       = 1'b0;
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= '0;
    cfg_data             <= '0;
    samples_if.valid     <= 1'b0;
    samples_if.pin_level <= 1'b0;
    pinned_valid         <= 1'b0;
    pinned_want          <= NO_RESULT;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part
    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_PIN: put_sample(plan[i].data[0], plan[i].pinned, plan[i].want);
        ROW_RES: begin
          settle();
          write_reg(CFG_SENSOR_RESOLUTION, plan[i].data);
        end
        default: begin
          settle();
          write_reg(CFG_ACTIVE_HIGH, plan[i].data);
        end
      endcase
    end

    // random part: mostly PWM periods with random shape, some noise
    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: res = 16'hFFFF;
        1: res = 16'd1;
        2: res = 16'($urandom);
        3: res = 16'd0;
        4: res = 16'($urandom_range(1, 15));
        default: res = 16'($urandom_range(1000, 8000));
      endcase
      write_reg(CFG_SENSOR_RESOLUTION, res);
      ah = (phase % 3 == 1) ? 1'b0 : 1'b1;
      write_reg(CFG_ACTIVE_HIGH, {15'($urandom), ah});
      gaps_on = !(phase == 1 || phase == 4);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (phase == 2 && !paused && sent >= PHASE_ITEMS / 2) begin
          // hold the sender until the back end has drained
          paused = 1'b1;
          samples_if.valid <= 1'b0;
          do @(posedge clk); while (pending_results.size() != 0);
        end
        choice = $urandom_range(0, 99);
        if (choice < 20) begin
          n = $urandom_range(1, 10);
          repeat (n) put_sample(1'($urandom), 1'b0, NO_RESULT);
          sent += n;
        end else begin
          if (choice < 80)
            per = $urandom_range(2, 12);
          else if (choice < 95)
            per = $urandom_range(13, 80);
          else
            per = $urandom_range(81, 300);
          on_len = $urandom_range(1, per - 1);
          // broken periods: never active or never inactive
          if ($urandom_range(0, 19) == 0)
            on_len = $urandom_range(0, 1) ? 0 : per;
          for (int k = 0; k < per; k++)
            put_sample((k < on_len) ? ah : !ah, 1'b0, NO_RESULT);
          sent += per;
        end
      end
    end

    settle();
    if (err_count == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

// ----- pwm_duty_capture_scaler.f -----
hw/rtl/pdcs_pkg.sv
hw/rtl/pdcs_if.sv
hw/rtl/pdcs_front.sv
hw/rtl/pdcs_queue.sv
hw/rtl/pdcs_back.sv
hw/rtl/pwm_duty_capture_scaler.sv
tb/sv/tb.sv
